// ===== rtl/core/gha_pkg.sv =====
// gha_pkg: shared constants, codes and controller/datapath types of the
// generational handle allocator; no dependencies
`default_nettype none

package gha_pkg;

   localparam int SLOTS      = 1024;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int GEN_W      = 8;
   localparam int CFG_W      = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int STATUS_W   = 3;

   localparam logic [CFG_W-1:0] MAX_SLOTS_RESET = CFG_W'(1024);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_FREE  = 2'd0,
      CSR_MAX_SLOTS = 2'd1
   } csr_addr_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CREATED     = 3'd0,
      ST_KILLED      = 3'd1,
      ST_STALE       = 3'd2,
      ST_FULL        = 3'd3,
      ST_BAD_INDEX   = 3'd4,
      ST_KILLED_WRAP = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FIFO_WAIT,
      S_GEN_CREATE,
      S_GEN_KILL,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic pop;
      logic gen_rd_req;
      logic gen_rd_fifo;
      logic append;
      logic set_full;
      logic set_bad;
      logic finish_create;
      logic finish_kill;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_kill;
      logic reuse;
      logic can_append;
      logic bad_index;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/gha_ifs.sv =====
// gha_ifs: valid/ready channel interfaces for requests, responses and csr writes
// depends on gha_pkg
`default_nettype none

interface gha_req_if;
   import gha_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [SLOT_W-1:0] handle_index;
   logic [GEN_W-1:0]  handle_generation;
   modport source (output valid, kind, handle_index, handle_generation, input ready);
   modport sink (input valid, kind, handle_index, handle_generation, output ready);
   modport monitor (input valid, ready, kind, handle_index, handle_generation);
endinterface

interface gha_rsp_if;
   import gha_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   result_index;
   logic [GEN_W-1:0]    result_generation;
   modport source (output valid, status, result_index, result_generation, input ready);
   modport sink (input valid, status, result_index, result_generation, output ready);
   modport monitor (input valid, ready, status, result_index, result_generation);
endinterface

interface gha_csr_if;
   import gha_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CFG_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

// ===== rtl/core/gha_ctrl.sv =====
// gha_ctrl: sequencing state machine of the allocator
// depends on gha_pkg; drives gha_dp through cmd_type, watches stat_type
`default_nettype none

module gha_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire gha_pkg::stat_type stat,
   output gha_pkg::cmd_type       cmd
);
   import gha_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.is_kill && stat.reuse) state_in = S_FIFO_WAIT;
            else if (stat.is_kill && !stat.bad_index) state_in = S_GEN_KILL;
            else state_in = S_RESULT;
         end
         S_FIFO_WAIT:  state_in = S_GEN_CREATE;
         S_GEN_CREATE: state_in = S_RESULT;
         S_GEN_KILL:   state_in = S_RESULT;
         S_RESULT: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECIDE: begin
            priority if (!stat.is_kill && stat.reuse) cmd.pop = 1'b1;
            else if (!stat.is_kill && stat.can_append) cmd.append = 1'b1;
            else if (!stat.is_kill) cmd.set_full = 1'b1;
            else if (stat.bad_index) cmd.set_bad = 1'b1;
            else cmd.gen_rd_req = 1'b1;
         end
         S_FIFO_WAIT:  cmd.gen_rd_fifo = 1'b1;
         S_GEN_CREATE: cmd.finish_create = 1'b1;
         S_GEN_KILL:   cmd.finish_kill = 1'b1;
         S_RESULT:     cmd.load_out = stat.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/gha_dp.sv =====
// gha_dp: allocator datapath with generation table, free fifo, counters,
// config registers and response register; depends on gha_pkg
`default_nettype none

module gha_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire gha_pkg::cmd_type                 cmd,
   output gha_pkg::stat_type                     stat,
   input  wire logic                             req_kind,
   input  wire logic [gha_pkg::SLOT_W-1:0]       req_index,
   input  wire logic [gha_pkg::GEN_W-1:0]        req_generation,
   input  wire logic                             csr_valid,
   input  wire logic [gha_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [gha_pkg::CFG_W-1:0]        csr_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output logic [gha_pkg::STATUS_W-1:0]          rsp_status,
   output logic [gha_pkg::SLOT_W-1:0]            rsp_index,
   output logic [gha_pkg::GEN_W-1:0]             rsp_generation
);
   import gha_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);

   logic [GEN_W-1:0]  gen_mem [SLOTS];
   logic [SLOT_W-1:0] fifo_mem [SLOTS];

   logic [CFG_W-1:0]  min_free_ff, max_slots_ff;
   logic [SLOT_W-1:0] head_ff, tail_ff;
   logic [CNT_W-1:0]  free_count_ff, slots_used_ff;
   logic              kind_ff;
   logic [SLOT_W-1:0] idx_ff, ridx_ff;
   logic [GEN_W-1:0]  hgen_ff;
   logic [GEN_W-1:0]  gen_rd_ff;
   logic [SLOT_W-1:0] fifo_rd_ff;
   status_type        pend_status_ff;
   logic [SLOT_W-1:0] pend_idx_ff;
   logic [GEN_W-1:0]  pend_gen_ff;
   logic              out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [SLOT_W-1:0] out_idx_ff;
   logic [GEN_W-1:0]  out_gen_ff;

   logic [CNT_W-1:0]  limit;
   logic              match;
   logic [GEN_W-1:0]  gen_inc;
   logic              push;
   logic              gen_we;
   logic [SLOT_W-1:0] gen_wa;
   logic [GEN_W-1:0]  gen_wd;
   logic              gen_re;
   logic [SLOT_W-1:0] gen_ra;

   assign limit   = (CNT_W'(max_slots_ff) < SLOTS_CNT) ? CNT_W'(max_slots_ff) : SLOTS_CNT;
   assign match   = (gen_rd_ff == hgen_ff);
   assign gen_inc = gen_rd_ff + GEN_W'(1);
   assign push    = cmd.finish_kill && match && (free_count_ff < SLOTS_CNT);

   assign stat.is_kill    = kind_ff;
   assign stat.reuse      = (free_count_ff > CNT_W'(min_free_ff)) ||
                            ((free_count_ff != '0) && (slots_used_ff >= limit));
   assign stat.can_append = (slots_used_ff < limit);
   assign stat.bad_index  = ({1'b0, idx_ff} >= slots_used_ff);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign gen_we = cmd.append || (cmd.finish_kill && match);
   assign gen_wa = cmd.append ? slots_used_ff[SLOT_W-1:0] : idx_ff;
   assign gen_wd = cmd.append ? '0 : gen_inc;
   assign gen_re = cmd.gen_rd_req || cmd.gen_rd_fifo;
   assign gen_ra = cmd.gen_rd_req ? idx_ff : fifo_rd_ff;

   // generation table
   always_ff @(posedge clock) begin
      if (gen_we) gen_mem[gen_wa] <= gen_wd;
      if (gen_re) gen_rd_ff <= gen_mem[gen_ra];
   end

   // free slot fifo
   always_ff @(posedge clock) begin
      if (push) fifo_mem[tail_ff] <= idx_ff;
      if (cmd.pop) fifo_rd_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_free_ff   <= '0;
         max_slots_ff  <= MAX_SLOTS_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_count_ff <= '0;
         slots_used_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_MIN_FREE)) min_free_ff <= csr_data;
         if (csr_valid && (csr_index == CSR_MAX_SLOTS)) max_slots_ff <= csr_data;
         if (cmd.pop) begin
            head_ff       <= (head_ff == LAST_SLOT) ? '0 : head_ff + SLOT_W'(1);
            free_count_ff <= free_count_ff - CNT_W'(1);
         end
         if (push) begin
            tail_ff       <= (tail_ff == LAST_SLOT) ? '0 : tail_ff + SLOT_W'(1);
            free_count_ff <= free_count_ff + CNT_W'(1);
         end
         if (cmd.append) slots_used_ff <= slots_used_ff + CNT_W'(1);
         if (cmd.load_out) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // transaction payload and pending result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         idx_ff  <= req_index;
         hgen_ff <= req_generation;
      end
      if (cmd.gen_rd_fifo) ridx_ff <= fifo_rd_ff;
      if (cmd.append) begin
         pend_status_ff <= ST_CREATED;
         pend_idx_ff    <= slots_used_ff[SLOT_W-1:0];
         pend_gen_ff    <= '0;
      end
      if (cmd.set_full || cmd.set_bad) begin
         if (cmd.set_full) pend_status_ff <= ST_FULL;
         else pend_status_ff <= ST_BAD_INDEX;
         pend_idx_ff    <= '0;
         pend_gen_ff    <= '0;
      end
      if (cmd.finish_create) begin
         pend_status_ff <= ST_CREATED;
         pend_idx_ff    <= ridx_ff;
         pend_gen_ff    <= gen_rd_ff;
      end
      if (cmd.finish_kill) begin
         if (!match) pend_status_ff <= ST_STALE;
         else if (gen_inc == '0) pend_status_ff <= ST_KILLED_WRAP;
         else pend_status_ff <= ST_KILLED;
         pend_idx_ff <= '0;
         pend_gen_ff <= '0;
      end
      if (cmd.load_out) begin
         out_status_ff <= pend_status_ff;
         out_idx_ff    <= pend_idx_ff;
         out_gen_ff    <= pend_gen_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_index      = out_idx_ff;
   assign rsp_generation = out_gen_ff;

endmodule

`default_nettype wire

// ===== rtl/core/generational_handle_allocator.sv =====
// generational_handle_allocator: top level, joins gha_ctrl and gha_dp
// depends on gha_pkg, gha_ifs, gha_ctrl, gha_dp
//
//  channel  | direction | payload
//  req_ch   | in        | kind, handle_index, handle_generation
//  rsp_ch   | out       | status, result_index, result_generation
//  csr_ch   | in        | index, data (always ready)
//
// one request at a time: create by append, full and bad index go through S_IDLE,
// S_DECIDE, S_RESULT; kill adds S_GEN_KILL, create by reuse S_FIFO_WAIT, S_GEN_CREATE
// (free fifo read, then generation read, both registered memory reads in series)
// the next request is taken while a response still waits in the output register
// reset is synchronous; the tables need no clearing pass
`default_nettype none

module generational_handle_allocator (
   input wire logic  clock,
   input wire logic  reset,
   gha_req_if.sink   req_ch,
   gha_rsp_if.source rsp_ch,
   gha_csr_if.sink   csr_ch
);
   import gha_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gha_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_ch.kind),
      .req_index      (req_ch.handle_index),
      .req_generation (req_ch.handle_generation),
      .csr_valid      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_status     (rsp_ch.status),
      .rsp_index      (rsp_ch.result_index),
      .rsp_generation (rsp_ch.result_generation)
   );

endmodule

`default_nettype wire

// ===== rtl/core/gha_checker.sv =====
// gha_checker: port-level assertions for the allocator, bound to the top level
// depends on gha_pkg
`default_nettype none

module gha_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [gha_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [gha_pkg::SLOT_W-1:0]   rsp_index,
   input wire logic [gha_pkg::GEN_W-1:0]    rsp_generation
);

   logic [1:0] pending_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) &&
         $stable(rsp_index) && $stable(rsp_generation))
      else $error("response payload changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pending_ff != 2'd0)
      else $error("response without request");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> pending_ff != 2'd2)
      else $error("request taken with two outstanding");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_index      (rsp_ch.result_index),
   .rsp_generation (rsp_ch.result_generation)
);

`default_nettype wire
